@@ design/lpfr_pkg.sv @@
package lpfr_pkg;

	localparam int SIZE_W = 11;
	localparam int LEN_W = 16;
	localparam int SUM_W = LEN_W + 1;
	localparam int BYTE_W = 8;
	localparam int FREE_W = 10;
	localparam int HDR_BYTES = 2;

	localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(3);
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

	typedef enum logic [1:0] {
		OP_WR_START = 2'd0,
		OP_WR_BYTE  = 2'd1,
		OP_RD_START = 2'd2,
		OP_RD_BYTE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FAIL  = 2'd1,
		STS_NOMEM = 2'd2,
		STS_EMPTY = 2'd3
	} sts_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_NOMEM,
		CMD_EMPTY,
		CMD_WR_HDR_HI,
		CMD_WR_HDR_LO,
		CMD_WR_BYTE,
		CMD_RD_HDR_HI,
		CMD_RD_HDR_LO,
		CMD_RD_HDR_CAP,
		CMD_RD_COMMIT,
		CMD_RD_BYTE,
		CMD_RD_DELIVER,
		CMD_OUT_LOAD
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic write_busy;
		logic read_busy;
		logic len_zero;
		logic limit_zero;
		logic no_room;
		logic ring_empty;
		logic rem_busy;
		logic out_free;
	} dp_stat_t;

endpackage

@@ design/lpfr_ram.sv @@
module lpfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/lpfr_rem.sv @@
module lpfr_rem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lpfr_pkg::SUM_W-1:0]  dividend,
	input  logic [lpfr_pkg::SIZE_W-1:0] divisor,
	output logic                        busy,
	output logic [lpfr_pkg::SIZE_W-1:0] remainder
);
	import lpfr_pkg::*;

	localparam int CNT_W = $clog2(SUM_W + 1);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W-1:0]   dvd_q;
	logic [SIZE_W-1:0]  rem_q;
	logic [SIZE_W:0]    trial;
	logic [SIZE_W:0]    diff;
	logic               ge;

	// restoring remainder, one dividend bit per cycle
	always_comb begin
		trial = {rem_q, dvd_q[SUM_W-1]};
		ge    = trial >= {1'b0, divisor};
		diff  = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(SUM_W);
			dvd_q  <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy      = busy_q;
	assign remainder = rem_q;

`ifndef ASSERT_OFF
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> (rem_q < divisor))
		else $error("remainder not below divisor");
`endif

endmodule

@@ design/lpfr_dp.sv @@
module lpfr_dp #(
	parameter int RING_DEPTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lpfr_pkg::dp_cmd_t           cmd,
	output lpfr_pkg::dp_stat_t          stat,
	input  logic                        cfg_wr_en,
	input  logic [lpfr_pkg::SIZE_W-1:0] cfg_wr_data,
	input  logic [1:0]                  opcode,
	input  logic [lpfr_pkg::BYTE_W-1:0] data_byte,
	input  logic [lpfr_pkg::LEN_W-1:0]  frame_length,
	input  logic [lpfr_pkg::LEN_W-1:0]  read_limit,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [lpfr_pkg::BYTE_W-1:0] out_byte,
	output logic [lpfr_pkg::LEN_W-1:0]  stored_length,
	output logic [lpfr_pkg::LEN_W-1:0]  deliver_count,
	output logic                        last_byte,
	output logic [lpfr_pkg::FREE_W-1:0] free_bytes,
	output logic                        is_empty,
	output logic                        is_full
);
	import lpfr_pkg::*;

	localparam int PW = $clog2(RING_DEPTH);
	localparam int CW = ((PW > SIZE_W) ? PW : SIZE_W) + 1;
	localparam logic [SIZE_W-1:0] SIZE_CAP =
		(RING_DEPTH >= (1 << SIZE_W)) ? {SIZE_W{1'b1}} : SIZE_W'(RING_DEPTH);

	// pointer state
	logic [SIZE_W-1:0] ring_size_q;
	logic [PW-1:0]     free_start_q;
	logic [PW-1:0]     data_start_q;
	logic [PW-1:0]     write_cursor_q;
	logic [LEN_W-1:0]  write_left_q;
	logic              write_busy_q;
	logic [PW-1:0]     read_cursor_q;
	logic [LEN_W-1:0]  read_left_q;
	logic [PW-1:0]     frame_end_q;
	logic              read_busy_q;
	logic              out_valid_q;

	// request and work registers
	op_t               opcode_q;
	logic [BYTE_W-1:0] data_byte_q;
	logic [LEN_W-1:0]  frame_length_q;
	logic [LEN_W-1:0]  read_limit_q;
	logic [PW-1:0]     ptr_q;
	logic [BYTE_W-1:0] hi_q;
	logic [LEN_W-1:0]  len_q;
	sts_t              sts_q;
	logic [BYTE_W-1:0] obyte_q;
	logic [LEN_W-1:0]  slen_q;
	logic [LEN_W-1:0]  dcount_q;
	logic              last_q;

	// result register
	logic [1:0]        status_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [LEN_W-1:0]  stored_length_q;
	logic [LEN_W-1:0]  deliver_count_q;
	logic              last_byte_q;
	logic [FREE_W-1:0] free_bytes_q;
	logic              is_empty_q;
	logic              is_full_q;

	logic [SIZE_W-1:0] size;
	logic [CW-1:0]     free_cnt;
	logic [PW-1:0]     wc_next;
	logic [LEN_W-1:0]  wl_next;
	logic [PW-1:0]     rc_next;
	logic [LEN_W-1:0]  rl_next;
	logic [LEN_W-1:0]  dcount;
	logic              no_room;

	logic              ram_we;
	logic [PW-1:0]     ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic              ram_re;
	logic [PW-1:0]     ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	logic              rem_start;
	logic [SUM_W-1:0]  rem_dividend;
	logic              rem_busy;
	logic [SIZE_W-1:0] rem_value;
	logic [PW-1:0]     rem_ptr;

	function automatic logic [PW-1:0] step_ptr(input logic [PW-1:0] p,
		input logic [SIZE_W-1:0] s);
		logic [CW-1:0] nxt;
		nxt = CW'(p) + CW'(1);
		return (nxt >= CW'(s)) ? '0 : PW'(nxt);
	endfunction

	always_comb begin
		if (ring_size_q < SIZE_MIN) begin
			size = SIZE_MIN;
		end else if (ring_size_q > SIZE_CAP) begin
			size = SIZE_CAP;
		end else begin
			size = ring_size_q;
		end
	end

	always_comb begin
		if (CW'(free_start_q) < CW'(data_start_q)) begin
			free_cnt = CW'(data_start_q) - CW'(free_start_q) - CW'(1);
		end else begin
			free_cnt = CW'(data_start_q) + CW'(size) - CW'(free_start_q) - CW'(1);
		end
	end

	always_comb begin
		no_room = SUM_W'(free_cnt) < ({1'b0, frame_length_q} + SUM_W'(HDR_BYTES));
		wc_next = step_ptr(write_cursor_q, size);
		wl_next = (write_left_q != '0) ? write_left_q - LEN_W'(1) : write_left_q;
		rc_next = step_ptr(read_cursor_q, size);
		rl_next = (read_left_q != '0) ? read_left_q - LEN_W'(1) : read_left_q;
		dcount  = (len_q < read_limit_q) ? len_q : read_limit_q;
		rem_ptr = PW'(rem_value);
	end

	always_comb begin
		stat.op         = opcode_q;
		stat.write_busy = write_busy_q;
		stat.read_busy  = read_busy_q;
		stat.len_zero   = (frame_length_q == '0);
		stat.limit_zero = (read_limit_q == '0);
		stat.no_room    = no_room;
		stat.ring_empty = (free_start_q == data_start_q);
		stat.rem_busy   = rem_busy;
		stat.out_free   = !out_valid_q || out_ready;
	end

	// memory ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = free_start_q;
		ram_wdata = frame_length_q[LEN_W-1:BYTE_W];
		ram_re    = 1'b0;
		ram_raddr = data_start_q;
		case (cmd)
			CMD_WR_HDR_HI: begin
				ram_we = 1'b1;
			end
			CMD_WR_HDR_LO: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = frame_length_q[BYTE_W-1:0];
			end
			CMD_WR_BYTE: begin
				ram_we    = 1'b1;
				ram_waddr = write_cursor_q;
				ram_wdata = data_byte_q;
			end
			CMD_RD_HDR_HI: begin
				ram_re = 1'b1;
			end
			CMD_RD_HDR_LO: begin
				ram_re    = 1'b1;
				ram_raddr = ptr_q;
			end
			CMD_RD_BYTE: begin
				ram_re    = 1'b1;
				ram_raddr = read_cursor_q;
			end
			default: begin
				ram_we = 1'b0;
				ram_re = 1'b0;
			end
		endcase
	end

	lpfr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(RING_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// frame end is (payload start + length) mod ring size
	assign rem_start    = (cmd == CMD_RD_HDR_CAP);
	assign rem_dividend = SUM_W'(ptr_q) + SUM_W'({hi_q, ram_rdata});

	lpfr_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (rem_dividend),
		.divisor  (size),
		.busy     (rem_busy),
		.remainder(rem_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q    <= SIZE_RESET;
			free_start_q   <= '0;
			data_start_q   <= '0;
			write_cursor_q <= '0;
			write_left_q   <= '0;
			write_busy_q   <= 1'b0;
			read_cursor_q  <= '0;
			read_left_q    <= '0;
			frame_end_q    <= '0;
			read_busy_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			// new size empties the ring
			ring_size_q    <= cfg_wr_data;
			free_start_q   <= '0;
			data_start_q   <= '0;
			write_cursor_q <= '0;
			write_left_q   <= '0;
			write_busy_q   <= 1'b0;
			read_cursor_q  <= '0;
			read_left_q    <= '0;
			frame_end_q    <= '0;
			read_busy_q    <= 1'b0;
		end else begin
			case (cmd)
				CMD_WR_HDR_LO: begin
					write_cursor_q <= step_ptr(ptr_q, size);
					write_left_q   <= frame_length_q;
					write_busy_q   <= 1'b1;
				end
				CMD_WR_BYTE: begin
					write_cursor_q <= wc_next;
					write_left_q   <= wl_next;
					if (wl_next == '0) begin
						free_start_q <= wc_next;
						write_busy_q <= 1'b0;
					end
				end
				CMD_RD_COMMIT: begin
					frame_end_q <= rem_ptr;
					if (dcount == '0) begin
						// zero header: skip at once
						data_start_q <= rem_ptr;
					end else begin
						read_cursor_q <= ptr_q;
						read_left_q   <= dcount;
						read_busy_q   <= 1'b1;
					end
				end
				CMD_RD_DELIVER: begin
					read_cursor_q <= rc_next;
					read_left_q   <= rl_next;
					if (rl_next == '0) begin
						data_start_q <= frame_end_q;
						read_busy_q  <= 1'b0;
					end
				end
				default: begin
					write_busy_q <= write_busy_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd == CMD_OUT_LOAD) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				opcode_q       <= op_t'(opcode);
				data_byte_q    <= data_byte;
				frame_length_q <= frame_length;
				read_limit_q   <= read_limit;
				sts_q          <= STS_FAIL;
				obyte_q        <= '0;
				slen_q         <= '0;
				dcount_q       <= '0;
				last_q         <= 1'b0;
			end
			CMD_NOMEM: begin
				sts_q <= STS_NOMEM;
			end
			CMD_EMPTY: begin
				sts_q <= STS_EMPTY;
			end
			CMD_WR_HDR_HI: begin
				ptr_q <= step_ptr(free_start_q, size);
			end
			CMD_WR_HDR_LO, CMD_WR_BYTE: begin
				sts_q <= STS_OK;
			end
			CMD_RD_HDR_HI: begin
				ptr_q <= step_ptr(data_start_q, size);
			end
			CMD_RD_HDR_LO: begin
				ptr_q <= step_ptr(ptr_q, size);
				hi_q  <= ram_rdata;
			end
			CMD_RD_HDR_CAP: begin
				len_q <= {hi_q, ram_rdata};
			end
			CMD_RD_COMMIT: begin
				sts_q    <= STS_OK;
				slen_q   <= len_q;
				dcount_q <= dcount;
			end
			CMD_RD_DELIVER: begin
				sts_q   <= STS_OK;
				obyte_q <= ram_rdata;
				last_q  <= (rl_next == '0);
			end
			CMD_OUT_LOAD: begin
				status_q        <= sts_q;
				out_byte_q      <= obyte_q;
				stored_length_q <= slen_q;
				deliver_count_q <= dcount_q;
				last_byte_q     <= last_q;
				free_bytes_q    <= FREE_W'(free_cnt);
				is_empty_q      <= (free_start_q == data_start_q);
				is_full_q       <= (free_cnt == '0);
			end
			default: begin
				sts_q <= sts_q;
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign out_byte      = out_byte_q;
	assign stored_length = stored_length_q;
	assign deliver_count = deliver_count_q;
	assign last_byte     = last_byte_q;
	assign free_bytes    = free_bytes_q;
	assign is_empty      = is_empty_q;
	assign is_full       = is_full_q;

`ifndef ASSERT_OFF
	a_ptr_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(CW'(free_start_q) < CW'(size)) && (CW'(data_start_q) < CW'(size)))
		else $error("ring pointer outside ring size");
	a_write_left: assert property (@(posedge clk) disable iff (!arst_n)
		write_busy_q |-> (write_left_q != '0))
		else $error("open write with nothing left");
	a_read_left: assert property (@(posedge clk) disable iff (!arst_n)
		read_busy_q |-> (read_left_q != '0))
		else $error("open read with nothing left");
`endif

endmodule

@@ design/lpfr_ctrl.sv @@
module lpfr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  lpfr_pkg::dp_stat_t stat,
	output lpfr_pkg::dp_cmd_t  cmd
);
	import lpfr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_WR_HDR_LO,
		S_RD_HDR_LO,
		S_RD_HDR_CAP,
		S_MOD_WAIT,
		S_RD_DELIVER,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd     = CMD_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FINISH;
				case (stat.op)
					OP_WR_START: begin
						if (!stat.write_busy && !stat.len_zero) begin
							if (stat.no_room) begin
								cmd = CMD_NOMEM;
							end else begin
								cmd     = CMD_WR_HDR_HI;
								state_d = S_WR_HDR_LO;
							end
						end
					end
					OP_WR_BYTE: begin
						if (stat.write_busy) begin
							cmd = CMD_WR_BYTE;
						end
					end
					OP_RD_START: begin
						if (!stat.read_busy && !stat.limit_zero) begin
							if (stat.ring_empty) begin
								cmd = CMD_EMPTY;
							end else begin
								cmd     = CMD_RD_HDR_HI;
								state_d = S_RD_HDR_LO;
							end
						end
					end
					OP_RD_BYTE: begin
						if (stat.read_busy) begin
							cmd     = CMD_RD_BYTE;
							state_d = S_RD_DELIVER;
						end
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_WR_HDR_LO: begin
				cmd     = CMD_WR_HDR_LO;
				state_d = S_FINISH;
			end
			S_RD_HDR_LO: begin
				cmd     = CMD_RD_HDR_LO;
				state_d = S_RD_HDR_CAP;
			end
			S_RD_HDR_CAP: begin
				cmd     = CMD_RD_HDR_CAP;
				state_d = S_MOD_WAIT;
			end
			S_MOD_WAIT: begin
				if (!stat.rem_busy) begin
					cmd     = CMD_RD_COMMIT;
					state_d = S_FINISH;
				end
			end
			S_RD_DELIVER: begin
				cmd     = CMD_RD_DELIVER;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				// hold the result until the output register frees up
				if (stat.out_free) begin
					cmd     = CMD_OUT_LOAD;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);

`ifndef ASSERT_OFF
	a_idle_rem_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !stat.rem_busy)
		else $error("remainder unit running while idle");
`endif

endmodule

@@ design/length_prefixed_frame_ring_fifo_core.sv @@
// Byte ring holding variable-length frames, each stored behind a two-byte
// big-endian length header. One request enters on the s_ side per operation
// (tuser opcode: write start, write byte, read start, read byte) and exactly
// one result leaves on the m_ side, in request order.
// A request is taken only when the core is idle; the result sits in an output
// register, so the next request is taken while that result waits for m_tready.
// A new request can be taken in the cycle after the previous result loads.
// Read start uses the bit-serial remainder unit that finds the frame end
// (17 steps, one dividend bit per cycle); the header takes two memory writes or
// two registered memory reads.
// A stalled receiver holds the result and the core waits in its finish state.
// Reset empties the ring, closes any open write or read and sets the ring
// size to 1024; a write on cfg_wr_en does the same with the new size and must
// only come while idle. The frame store itself is not cleared.
module length_prefixed_frame_ring_fifo_core #(
	parameter int RING_DEPTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [lpfr_pkg::SIZE_W-1:0] cfg_wr_data,  // ring_size
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [39:0]                 s_tdata,   // data_byte, frame_length, read_limit
	input  logic [1:0]                  s_tuser,   // opcode
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// status, out_byte, stored_length, deliver_count, free_bytes, is_empty, is_full
	output logic [55:0]                 m_tdata,
	output logic                        m_tlast    // last_byte
);
	import lpfr_pkg::*;

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [1:0]        status;
	logic [BYTE_W-1:0] out_byte;
	logic [LEN_W-1:0]  stored_length;
	logic [LEN_W-1:0]  deliver_count;
	logic [FREE_W-1:0] free_bytes;
	logic              is_empty;
	logic              is_full;

	lpfr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	lpfr_dp #(
		.RING_DEPTH(RING_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.opcode       (s_tuser),
		.data_byte    (s_tdata[7:0]),
		.frame_length (s_tdata[23:8]),
		.read_limit   (s_tdata[39:24]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.status       (status),
		.out_byte     (out_byte),
		.stored_length(stored_length),
		.deliver_count(deliver_count),
		.last_byte    (m_tlast),
		.free_bytes   (free_bytes),
		.is_empty     (is_empty),
		.is_full      (is_full)
	);

	assign m_tdata = {2'b00, is_full, is_empty, free_bytes, deliver_count,
		stored_length, out_byte, status};

endmodule
